// ===== sv/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer package
// Item types, register map, reset values and codes shared by the block,
// its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package bps_pkg;

    // Width of the configuration registers and of the pattern timers.
    localparam int unsigned CntW = 8;

    // APB register map: register i lies at byte address 4*i.
    localparam int unsigned AddrW = 5;
    localparam int unsigned DataW = 32;
    localparam logic [2:0] REG_KEY_BEEP_TICKS   = 3'd0;
    localparam logic [2:0] REG_LONG_BEEP_TICKS  = 3'd1;
    localparam logic [2:0] REG_LONG_BEEP_HALVES = 3'd2;
    localparam logic [2:0] REG_ALARM_ON_TICKS   = 3'd3;
    localparam logic [2:0] REG_ALARM_OFF_TICKS  = 3'd4;
    localparam logic [2:0] REG_SWITCH_GAP_TICKS = 3'd5;

    // Register reset values.
    localparam logic [CntW-1:0] RST_KEY_BEEP_TICKS   = 8'd4;
    localparam logic [CntW-1:0] RST_LONG_BEEP_TICKS  = 8'd10;
    localparam logic [CntW-1:0] RST_LONG_BEEP_HALVES = 8'd4;
    localparam logic [CntW-1:0] RST_ALARM_ON_TICKS   = 8'd3;
    localparam logic [CntW-1:0] RST_ALARM_OFF_TICKS  = 8'd2;
    localparam logic [CntW-1:0] RST_SWITCH_GAP_TICKS = 8'd3;

    // Fault status codes; the unused code behaves as an active fault.
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_ENDED = 2'd2;

    // Mute icon commands.
    localparam logic [1:0] ICON_NONE  = 2'd0;
    localparam logic [1:0] ICON_SHOW  = 2'd1;
    localparam logic [1:0] ICON_CLEAR = 2'd2;

    // Bit positions in the pattern masks.
    localparam int unsigned PAT_KEY   = 0;
    localparam int unsigned PAT_LONG  = 1;
    localparam int unsigned PAT_ALARM = 2;

    // Bit positions in the phase flags (set means silent phase).
    localparam int unsigned PH_LONG  = 0;
    localparam int unsigned PH_ALARM = 1;

    // Sound state machine.
    typedef enum logic [1:0] {
        SND_ON     = 2'd0,
        SND_MUTE   = 2'd1,
        SND_CANCEL = 2'd2
    } t_snd_state;

    // One control tick.
    typedef struct packed {
        logic       key_beep;
        logic       refusal_beep;
        logic       update_request;
        logic       cancel_set;
        logic       cancel_clear;
        logic [1:0] fault_status;
        logic       mute_setting;
    } t_in_item;

    // One result per tick.
    typedef struct packed {
        logic       buzzer_level;
        logic [1:0] mute_icon_cmd;
    } t_out_item;

endpackage

// ===== sv/bps_if.sv =====
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer channels
// Valid/ready channels for tick items and result items.
// ----------------------------------------------------------------------------
interface bps_in_if;
    logic               valid;
    logic               ready;
    bps_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bps_out_if;
    logic               valid;
    logic               ready;
    bps_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/buzzer_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer
// Applies one control tick per item and sequences key beep, long beep and
// alarm patterns behind a sound/mute/cancel state machine.
// ----------------------------------------------------------------------------
// Usage:
// Tick items arrive on i_in (valid/ready); each gives exactly one result item
// on o_out with the buzzer level after the tick and a mute icon command.
// An item is accepted at a clock edge with valid and ready both high.
// The tick is captured in an input register at the accepting edge, and the
// whole tick update is one pass of combinational logic that writes the state
// and the result register when the result register is empty or being emptied.
// Throughput is one item per cycle while the receiver keeps ready high.
// When the receiver stalls, the result holds, the input register takes one
// more tick which then waits, and i_in.ready drops once both registers are
// full.
// The APB port sets the six 8-bit pattern timings (byte address 4*i); pready
// is always high and writes take effect at the access cycle. Write them only
// while no item is in flight.
// Reset (i_rst_n low, synchronous) empties both registers, restores default
// timings and puts the buzzer off in the sounding state with no pattern.
// ----------------------------------------------------------------------------
module buzzer_pattern_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    bps_in_if.sink                           i_in,
    bps_out_if.source                        o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bps_pkg::AddrW-1:0]        paddr,
    input  logic [bps_pkg::DataW-1:0]        pwdata,
    output logic [bps_pkg::DataW-1:0]        prdata,
    output logic                             pready
);

    localparam int unsigned W = bps_pkg::CntW;

    // Configuration registers.
    logic [W-1:0] r_key_beep_ticks, r_long_beep_ticks, r_long_beep_halves;
    logic [W-1:0] r_alarm_on_ticks, r_alarm_off_ticks, r_switch_gap_ticks;
    logic [2:0]   reg_idx;
    logic         cfg_wr;
    logic [W-1:0] rd_val;

    // Pipeline registers.
    logic                r_in_valid;
    bps_pkg::t_in_item   r_in;
    logic                r_out_valid;
    bps_pkg::t_out_item  r_out;
    logic                advance;

    // Tick state.
    bps_pkg::t_snd_state r_sound_state, n_sound_state;
    logic         r_last_chirp, n_last_chirp;
    logic         r_cancel_alarm, n_cancel_alarm;
    logic [2:0]   r_pattern_active, n_pattern_active;
    logic [W-1:0] r_key_timer, n_key_timer;
    logic [W-1:0] r_long_timer, n_long_timer;
    logic [W-1:0] r_long_halves_left, n_long_halves_left;
    logic [W-1:0] r_alarm_timer, n_alarm_timer;
    logic [2:0]   r_was_playing, n_was_playing;
    logic [1:0]   r_phase_flags, n_phase_flags;
    logic [W-1:0] r_gap_key, n_gap_key;
    logic [W-1:0] r_gap_long, n_gap_long;
    logic [W-1:0] r_gap_alarm, n_gap_alarm;
    logic         r_buzzer, n_buzzer;

    // Values after the tick's events and fault handling.
    logic         e_cancel;
    logic         e_eval;
    logic         e_buzzer;
    logic [2:0]   e_pattern;
    logic [W-1:0] e_key_timer, e_long_timer, e_long_halves;

    // Sound state machine outputs.
    logic         s_chirp_set;
    logic         s_drop_long;
    logic         s_drop_alarm;
    logic [1:0]   s_icon;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign reg_idx = paddr[bps_pkg::AddrW-1:2];
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_beep_ticks   <= bps_pkg::RST_KEY_BEEP_TICKS;
            r_long_beep_ticks  <= bps_pkg::RST_LONG_BEEP_TICKS;
            r_long_beep_halves <= bps_pkg::RST_LONG_BEEP_HALVES;
            r_alarm_on_ticks   <= bps_pkg::RST_ALARM_ON_TICKS;
            r_alarm_off_ticks  <= bps_pkg::RST_ALARM_OFF_TICKS;
            r_switch_gap_ticks <= bps_pkg::RST_SWITCH_GAP_TICKS;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                bps_pkg::REG_KEY_BEEP_TICKS:   r_key_beep_ticks   <= pwdata[W-1:0];
                bps_pkg::REG_LONG_BEEP_TICKS:  r_long_beep_ticks  <= pwdata[W-1:0];
                bps_pkg::REG_LONG_BEEP_HALVES: r_long_beep_halves <= pwdata[W-1:0];
                bps_pkg::REG_ALARM_ON_TICKS:   r_alarm_on_ticks   <= pwdata[W-1:0];
                bps_pkg::REG_ALARM_OFF_TICKS:  r_alarm_off_ticks  <= pwdata[W-1:0];
                bps_pkg::REG_SWITCH_GAP_TICKS: r_switch_gap_ticks <= pwdata[W-1:0];
                default: ;
            endcase
        end
    end

    // Read data mux; unused addresses read as zero.
    always_comb begin
        unique case (reg_idx)
            bps_pkg::REG_KEY_BEEP_TICKS:   rd_val = r_key_beep_ticks;
            bps_pkg::REG_LONG_BEEP_TICKS:  rd_val = r_long_beep_ticks;
            bps_pkg::REG_LONG_BEEP_HALVES: rd_val = r_long_beep_halves;
            bps_pkg::REG_ALARM_ON_TICKS:   rd_val = r_alarm_on_ticks;
            bps_pkg::REG_ALARM_OFF_TICKS:  rd_val = r_alarm_off_ticks;
            bps_pkg::REG_SWITCH_GAP_TICKS: rd_val = r_switch_gap_ticks;
            default:                       rd_val = '0;
        endcase
    end
    assign prdata = {{(bps_pkg::DataW - W){1'b0}}, rd_val};

    // ------------------------------------------------------------------
    // Handshake: the captured tick moves on whenever the result register
    // is empty or is being emptied this cycle.
    // ------------------------------------------------------------------
    assign advance     = r_in_valid & (~r_out_valid | o_out.ready);
    assign i_in.ready  = ~r_in_valid | advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (advance) begin
            r_out.buzzer_level  <= n_buzzer;
            r_out.mute_icon_cmd <= s_icon;
        end
    end

    // ------------------------------------------------------------------
    // Events, then fault handling. An update request is consumed in the
    // same tick, so no pending flag survives between ticks.
    // ------------------------------------------------------------------
    always_comb begin
        e_cancel = r_cancel_alarm;
        if (r_in.cancel_set) begin
            e_cancel = 1'b1;
        end
        if (r_in.cancel_clear) begin
            e_cancel = 1'b0;
        end

        e_buzzer      = r_buzzer;
        e_pattern     = r_pattern_active;
        e_key_timer   = r_key_timer;
        e_long_timer  = r_long_timer;
        e_long_halves = r_long_halves_left;
        if (r_in.key_beep) begin
            e_buzzer           = 1'b0;
            e_pattern[bps_pkg::PAT_KEY] = 1'b1;
            e_key_timer        = r_key_beep_ticks;
        end
        if (r_in.refusal_beep) begin
            e_pattern[bps_pkg::PAT_LONG] = 1'b1;
            e_long_timer  = r_long_beep_ticks;
            e_long_halves = r_long_beep_halves;
        end
        e_eval = r_in.update_request;

        // All faults ended stops the alarm and re-arms a cancelled alarm.
        if (r_in.fault_status == bps_pkg::FAULT_ENDED) begin
            e_buzzer = 1'b0;
            e_pattern[bps_pkg::PAT_ALARM] = 1'b0;
            if (e_cancel) begin
                e_cancel = 1'b0;
                e_eval   = 1'b1;
            end
        end else if (r_in.fault_status != bps_pkg::FAULT_NONE && !e_cancel) begin
            e_pattern[bps_pkg::PAT_ALARM] = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sound state machine: next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_sound_state = r_sound_state;
        if (e_eval) begin
            unique case (r_sound_state)
                bps_pkg::SND_ON: begin
                    if (r_in.mute_setting) begin
                        n_sound_state = bps_pkg::SND_MUTE;
                    end else if (e_cancel) begin
                        n_sound_state = bps_pkg::SND_CANCEL;
                    end
                end
                bps_pkg::SND_MUTE: begin
                    if (!r_in.mute_setting) begin
                        n_sound_state = bps_pkg::SND_ON;
                    end
                end
                bps_pkg::SND_CANCEL: begin
                    if (r_in.mute_setting) begin
                        n_sound_state = bps_pkg::SND_MUTE;
                    end else if (!e_cancel) begin
                        n_sound_state = bps_pkg::SND_ON;
                    end
                end
                default: ;
            endcase
        end
    end

    // Sound state machine: outputs.
    always_comb begin
        s_chirp_set  = 1'b0;
        s_drop_long  = 1'b0;
        s_drop_alarm = 1'b0;
        s_icon       = bps_pkg::ICON_NONE;
        if (e_eval) begin
            unique case (r_sound_state)
                bps_pkg::SND_ON: begin
                    if (r_in.mute_setting) begin
                        s_drop_long = 1'b1;
                        s_chirp_set = 1'b1;
                        s_icon      = bps_pkg::ICON_SHOW;
                    end else if (e_cancel) begin
                        s_chirp_set  = 1'b1;
                        s_drop_alarm = 1'b1;
                    end
                end
                bps_pkg::SND_MUTE: begin
                    if (!r_in.mute_setting) begin
                        s_icon = bps_pkg::ICON_CLEAR;
                    end
                end
                bps_pkg::SND_CANCEL: begin
                    if (r_in.mute_setting) begin
                        s_chirp_set = 1'b1;
                        s_icon      = bps_pkg::ICON_SHOW;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pattern sequencing: the key beep wins over the long beep, which wins
    // over the alarm. Entering a pattern after another one has played
    // starts a silent gap first, but the long beep gaps only after the key beep.
    // ------------------------------------------------------------------
    always_comb begin
        n_cancel_alarm     = e_cancel;
        n_buzzer           = e_buzzer;
        n_pattern_active   = e_pattern;
        n_key_timer        = e_key_timer;
        n_long_timer       = e_long_timer;
        n_long_halves_left = e_long_halves;
        n_alarm_timer      = r_alarm_timer;
        n_was_playing      = r_was_playing;
        n_phase_flags      = r_phase_flags;
        n_gap_key          = r_gap_key;
        n_gap_long         = r_gap_long;
        n_gap_alarm        = r_gap_alarm;
        n_last_chirp       = r_last_chirp | s_chirp_set;
        if (s_drop_long) begin
            n_pattern_active[bps_pkg::PAT_LONG] = 1'b0;
        end
        if (s_drop_alarm) begin
            n_pattern_active[bps_pkg::PAT_ALARM] = 1'b0;
        end

        if (!r_in.mute_setting || n_last_chirp) begin
            priority if (n_pattern_active[bps_pkg::PAT_KEY]) begin
                // Key beep: a switch restarts both other patterns silent.
                if (r_was_playing[bps_pkg::PAT_ALARM] || r_was_playing[bps_pkg::PAT_LONG]) begin
                    n_buzzer      = 1'b0;
                    n_gap_key     = r_switch_gap_ticks;
                    n_was_playing[bps_pkg::PAT_ALARM] = 1'b0;
                    n_was_playing[bps_pkg::PAT_LONG]  = 1'b0;
                    n_phase_flags = 2'b11;
                    n_alarm_timer = r_alarm_on_ticks;
                end
                if (n_gap_key == '0) begin
                    n_buzzer = 1'b1;
                    n_was_playing[bps_pkg::PAT_KEY] = 1'b1;
                    if (n_key_timer == '0) begin
                        n_buzzer     = 1'b0;
                        n_pattern_active[bps_pkg::PAT_KEY] = 1'b0;
                        n_last_chirp = 1'b0;
                    end else begin
                        n_key_timer = n_key_timer - 1'b1;
                    end
                end else begin
                    n_gap_key = n_gap_key - 1'b1;
                end
            end else if (n_pattern_active[bps_pkg::PAT_LONG]) begin
                // Long beep: on/off halves until the half count runs out.
                if (r_was_playing[bps_pkg::PAT_KEY]) begin
                    n_buzzer   = 1'b0;
                    n_gap_long = r_switch_gap_ticks;
                    n_was_playing[bps_pkg::PAT_KEY] = 1'b0;
                end
                if (n_gap_long == '0) begin
                    n_was_playing[bps_pkg::PAT_LONG] = 1'b1;
                    if (n_long_halves_left != '0) begin
                        if (n_long_timer != '0) begin
                            n_buzzer     = ~r_phase_flags[bps_pkg::PH_LONG];
                            n_long_timer = n_long_timer - 1'b1;
                        end else begin
                            n_long_halves_left = n_long_halves_left - 1'b1;
                            n_phase_flags[bps_pkg::PH_LONG] = ~r_phase_flags[bps_pkg::PH_LONG];
                            n_long_timer = r_long_beep_ticks;
                        end
                    end else begin
                        n_buzzer = 1'b0;
                        n_pattern_active[bps_pkg::PAT_LONG] = 1'b0;
                    end
                end else begin
                    n_gap_long = n_gap_long - 1'b1;
                end
            end else if (n_pattern_active[bps_pkg::PAT_ALARM]) begin
                // Alarm: endless on/off with separate reloads per phase.
                if (r_was_playing[bps_pkg::PAT_KEY] || r_was_playing[bps_pkg::PAT_LONG]) begin
                    n_buzzer    = 1'b0;
                    n_gap_alarm = r_switch_gap_ticks;
                    n_was_playing[bps_pkg::PAT_KEY]  = 1'b0;
                    n_was_playing[bps_pkg::PAT_LONG] = 1'b0;
                end
                if (n_gap_alarm == '0) begin
                    n_was_playing[bps_pkg::PAT_ALARM] = 1'b1;
                    if (r_alarm_timer != '0) begin
                        n_buzzer      = ~r_phase_flags[bps_pkg::PH_ALARM];
                        n_alarm_timer = r_alarm_timer - 1'b1;
                    end else begin
                        n_phase_flags[bps_pkg::PH_ALARM] = ~r_phase_flags[bps_pkg::PH_ALARM];
                        n_alarm_timer = r_phase_flags[bps_pkg::PH_ALARM] ?
                                        r_alarm_on_ticks : r_alarm_off_ticks;
                    end
                end else begin
                    n_gap_alarm = n_gap_alarm - 1'b1;
                end
            end else begin
                n_buzzer = n_buzzer;
            end
        end
    end

    // State update, once per tick that moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound_state      <= bps_pkg::SND_ON;
            r_last_chirp       <= 1'b0;
            r_cancel_alarm     <= 1'b0;
            r_pattern_active   <= '0;
            r_key_timer        <= '0;
            r_long_timer       <= '0;
            r_long_halves_left <= '0;
            r_alarm_timer      <= '0;
            r_was_playing      <= '0;
            r_phase_flags      <= '0;
            r_gap_key          <= '0;
            r_gap_long         <= '0;
            r_gap_alarm        <= '0;
            r_buzzer           <= 1'b0;
        end else if (advance) begin
            r_sound_state      <= n_sound_state;
            r_last_chirp       <= n_last_chirp;
            r_cancel_alarm     <= n_cancel_alarm;
            r_pattern_active   <= n_pattern_active;
            r_key_timer        <= n_key_timer;
            r_long_timer       <= n_long_timer;
            r_long_halves_left <= n_long_halves_left;
            r_alarm_timer      <= n_alarm_timer;
            r_was_playing      <= n_was_playing;
            r_phase_flags      <= n_phase_flags;
            r_gap_key          <= n_gap_key;
            r_gap_long         <= n_gap_long;
            r_gap_alarm        <= n_gap_alarm;
            r_buzzer           <= n_buzzer;
        end
    end

endmodule

// ===== sv/bps_checker.sv =====
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer checker
// Port-level properties of the sequencer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bps_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    bps_in_if.sink                    i_in,
    bps_out_if.source                 o_out,
    input  logic                      pready
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

    // Every accepted item has a result valid once it has passed both pipeline registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> ##1 o_out.valid)
        else $error("accepted item produced no result");

    // The icon command only takes one of its three codes.
    a_icon_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.mute_icon_cmd == bps_pkg::ICON_NONE ||
                         o_out.data.mute_icon_cmd == bps_pkg::ICON_SHOW ||
                         o_out.data.mute_icon_cmd == bps_pkg::ICON_CLEAR))
        else $error("illegal mute icon command");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.data)))
        else $error("stalled result changed");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind buzzer_pattern_sequencer bps_checker u_bps_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out),
    .pready  (pready)
);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer testbench
// Drives control ticks into the sequencer over its valid/ready channel, keeps
// a cycle-free model of the tick update, and checks every result item field by
// field in order. A short table of hand-picked ticks comes first. Several
// phases of biased random ticks follow, each under its own pattern timings
// written over APB, with the sender and receiver idling at random in most phases.
// ----------------------------------------------------------------------------
module testbench;
    import bps_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS = 25;
    localparam int PHASE_ITEMS = 205;
    localparam int TickW = $bits(t_in_item);
    localparam int MAX_REPORTS = 10;

    // Fault codes the package leaves unnamed.
    localparam logic [1:0] FAULT_ACTIVE = 2'd1;
    localparam logic [1:0] FAULT_SPARE  = 2'd3;

    // One row of the directed table; want is used only where typed is set.
    typedef struct packed {
        t_in_item  tick;
        logic      typed;
        t_out_item want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
    logic [DataW-1:0] prdata;
    logic pready;

    bps_in_if tick_ch ();
    bps_out_if res_ch ();

    buzzer_pattern_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .o_out   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Model copy of the timing registers and of the sequencer state.
    logic [CntW-1:0] timing [0:5];
    t_snd_state      snd;
    logic            upd_pend;
    logic            chirp;
    logic            cancel;
    logic [2:0]      pat_on;
    logic [2:0]      pat_was;
    logic [CntW-1:0] key_left;
    logic [CntW-1:0] long_left;
    logic [CntW-1:0] halves_left;
    logic [CntW-1:0] alarm_left;
    logic [1:0]      silent;
    logic [CntW-1:0] gap_left [0:2];
    logic            buzz;

    t_out_item expected_outs [$];
    int        errors = 0;
    int        results_seen = 0;
    int        cycles = 0;
    int        snd_idle_pct;
    int        rcv_idle_pct;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    logic      mute_sel = 1'b0;
    t_row      dir_plan [DIR_ROWS];

    function automatic void reset_buzzer_model();
        timing[REG_KEY_BEEP_TICKS]   = RST_KEY_BEEP_TICKS;
        timing[REG_LONG_BEEP_TICKS]  = RST_LONG_BEEP_TICKS;
        timing[REG_LONG_BEEP_HALVES] = RST_LONG_BEEP_HALVES;
        timing[REG_ALARM_ON_TICKS]   = RST_ALARM_ON_TICKS;
        timing[REG_ALARM_OFF_TICKS]  = RST_ALARM_OFF_TICKS;
        timing[REG_SWITCH_GAP_TICKS] = RST_SWITCH_GAP_TICKS;
        snd = SND_ON;
        upd_pend = 1'b0;
        chirp = 1'b0;
        cancel = 1'b0;
        pat_on = '0;
        pat_was = '0;
        key_left = '0;
        long_left = '0;
        halves_left = '0;
        alarm_left = '0;
        silent = '0;
        gap_left[PAT_KEY] = '0;
        gap_left[PAT_LONG] = '0;
        gap_left[PAT_ALARM] = '0;
        buzz = 1'b0;
    endfunction

    // Applies one tick to the model state and returns the result item.
    function automatic t_out_item buzzer_after_tick(t_in_item t);
        t_out_item r;
        r.mute_icon_cmd = ICON_NONE;

        // Events: clear wins over set, then key, refusal and update.
        if (t.cancel_set) cancel = 1'b1;
        if (t.cancel_clear) cancel = 1'b0;
        if (t.key_beep) begin
            buzz = 1'b0;
            pat_on[PAT_KEY] = 1'b1;
            key_left = timing[REG_KEY_BEEP_TICKS];
        end
        if (t.refusal_beep) begin
            pat_on[PAT_LONG] = 1'b1;
            long_left = timing[REG_LONG_BEEP_TICKS];
            halves_left = timing[REG_LONG_BEEP_HALVES];
        end
        if (t.update_request) upd_pend = 1'b1;

        // Fault status; the unused code counts as an active fault.
        if (t.fault_status == FAULT_ENDED) begin
            buzz = 1'b0;
            pat_on[PAT_ALARM] = 1'b0;
            if (cancel) begin
                cancel = 1'b0;
                upd_pend = 1'b1;
            end
        end else if (t.fault_status != FAULT_NONE && !cancel) begin
            pat_on[PAT_ALARM] = 1'b1;
        end

        // Sound state machine, evaluated only on a pending update.
        if (upd_pend) begin
            upd_pend = 1'b0;
            case (snd)
                SND_ON: begin
                    if (t.mute_setting) begin
                        pat_on[PAT_LONG] = 1'b0;
                        snd = SND_MUTE;
                        chirp = 1'b1;
                        r.mute_icon_cmd = ICON_SHOW;
                    end else if (cancel) begin
                        snd = SND_CANCEL;
                        chirp = 1'b1;
                        pat_on[PAT_ALARM] = 1'b0;
                    end
                end
                SND_MUTE: begin
                    if (!t.mute_setting) begin
                        snd = SND_ON;
                        r.mute_icon_cmd = ICON_CLEAR;
                    end
                end
                SND_CANCEL: begin
                    if (t.mute_setting) begin
                        r.mute_icon_cmd = ICON_SHOW;
                        snd = SND_MUTE;
                        chirp = 1'b1;
                    end else if (!cancel) begin
                        snd = SND_ON;
                    end
                end
                default: ;
            endcase
        end

        // Pattern sequencing in priority order, with a silent gap on a switch.
        if (!t.mute_setting || chirp) begin
            if (pat_on[PAT_KEY]) begin
                if (pat_was[PAT_ALARM] || pat_was[PAT_LONG]) begin
                    buzz = 1'b0;
                    gap_left[PAT_KEY] = timing[REG_SWITCH_GAP_TICKS];
                    pat_was[PAT_ALARM] = 1'b0;
                    pat_was[PAT_LONG] = 1'b0;
                    silent = 2'b11;
                    alarm_left = timing[REG_ALARM_ON_TICKS];
                end
                if (gap_left[PAT_KEY] == 0) begin
                    buzz = 1'b1;
                    pat_was[PAT_KEY] = 1'b1;
                    if (key_left == 0) begin
                        buzz = 1'b0;
                        pat_on[PAT_KEY] = 1'b0;
                        chirp = 1'b0;
                    end else begin
                        key_left = key_left - 1'b1;
                    end
                end else begin
                    gap_left[PAT_KEY] = gap_left[PAT_KEY] - 1'b1;
                end
            end else if (pat_on[PAT_LONG]) begin
                if (pat_was[PAT_KEY]) begin
                    buzz = 1'b0;
                    gap_left[PAT_LONG] = timing[REG_SWITCH_GAP_TICKS];
                    pat_was[PAT_KEY] = 1'b0;
                end
                if (gap_left[PAT_LONG] == 0) begin
                    pat_was[PAT_LONG] = 1'b1;
                    if (halves_left != 0) begin
                        if (long_left != 0) begin
                            buzz = !silent[PH_LONG];
                            long_left = long_left - 1'b1;
                        end else begin
                            halves_left = halves_left - 1'b1;
                            silent[PH_LONG] = !silent[PH_LONG];
                            long_left = timing[REG_LONG_BEEP_TICKS];
                        end
                    end else begin
                        buzz = 1'b0;
                        pat_on[PAT_LONG] = 1'b0;
                    end
                end else begin
                    gap_left[PAT_LONG] = gap_left[PAT_LONG] - 1'b1;
                end
            end else if (pat_on[PAT_ALARM]) begin
                if (pat_was[PAT_KEY] || pat_was[PAT_LONG]) begin
                    buzz = 1'b0;
                    gap_left[PAT_ALARM] = timing[REG_SWITCH_GAP_TICKS];
                    pat_was[PAT_KEY] = 1'b0;
                    pat_was[PAT_LONG] = 1'b0;
                end
                if (gap_left[PAT_ALARM] == 0) begin
                    pat_was[PAT_ALARM] = 1'b1;
                    if (alarm_left != 0) begin
                        buzz = !silent[PH_ALARM];
                        alarm_left = alarm_left - 1'b1;
                    end else begin
                        silent[PH_ALARM] = !silent[PH_ALARM];
                        alarm_left = silent[PH_ALARM] ? timing[REG_ALARM_OFF_TICKS]
                                                      : timing[REG_ALARM_ON_TICKS];
                    end
                end else begin
                    gap_left[PAT_ALARM] = gap_left[PAT_ALARM] - 1'b1;
                end
            end
        end

        r.buzzer_level = buzz;
        return r;
    endfunction

    // Biased random tick: rare events, a slowly changing mute setting and
    // some fully random noise.
    function automatic t_in_item random_tick();
        t_in_item t;
        int f;
        if ($urandom_range(0, 99) < 3) mute_sel = !mute_sel;
        if ($urandom_range(0, 9) == 0) begin
            t = TickW'($urandom);
            return t;
        end
        t.key_beep = $urandom_range(0, 99) < 6;
        t.refusal_beep = $urandom_range(0, 99) < 5;
        t.update_request = $urandom_range(0, 99) < 12;
        t.cancel_set = $urandom_range(0, 99) < 5;
        t.cancel_clear = $urandom_range(0, 99) < 5;
        f = $urandom_range(0, 99);
        t.fault_status = (f < 80) ? FAULT_NONE : (f < 90) ? FAULT_ACTIVE :
                         (f < 96) ? FAULT_ENDED : FAULT_SPARE;
        t.mute_setting = mute_sel;
        return t;
    endfunction

    function automatic void note_mismatch(string why, t_out_item want, t_out_item got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("mismatch at %0t: %s expected buzzer=%0d icon=%0d got buzzer=%0d icon=%0d",
                     $realtime, why, want.buzzer_level, want.mute_icon_cmd,
                     got.buzzer_level, got.mute_icon_cmd);
    endfunction

    // Offers one tick, called and returning at a falling edge. The expected
    // result is queued at the edge where the tick is accepted.
    task automatic offer_tick(t_in_item t, logic typed, t_out_item want);
        t_out_item model_out;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data <= t;
        do @(posedge i_clk); while (!tick_ch.ready);
        model_out = buzzer_after_tick(t);
        expected_outs.push_back(typed ? want : model_out);
        @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_timing(logic [2:0] idx, logic [CntW-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= DataW'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        timing[idx] = val;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    // Waits until the block is empty, loads new timings, then runs random ticks.
    // Timings are packed with key_beep_ticks in the low byte.
    task automatic run_phase(logic [6*CntW-1:0] timings, int snd_pct, int rcv_pct);
        tick_ch.valid <= 1'b0;
        while (expected_outs.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        for (int r = REG_KEY_BEEP_TICKS; r <= REG_SWITCH_GAP_TICKS; r++)
            write_timing(3'(r), timings[r*CntW +: CntW]);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        repeat (PHASE_ITEMS) offer_tick(random_tick(), 1'b0, '0);
    endtask

    // Receiver: random stalls, plus one long hold-off that fills the block.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
        end else if (!hold_done && results_seen >= 100) begin
            hold_done = 1'b1;
            hold_left = 120;
        end
        res_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (expected_outs.size() == 0) begin
                note_mismatch("result with none expected,", '0, res_ch.data);
            end else begin
                want = expected_outs.pop_front();
                if (res_ch.data.buzzer_level !== want.buzzer_level ||
                    res_ch.data.mute_icon_cmd !== want.mute_icon_cmd)
                    note_mismatch("result", want, res_ch.data);
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        reset_buzzer_model();
        i_rst_n = 1'b0;
        tick_ch.valid = 1'b0;
        tick_ch.data = '0;
        res_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        snd_idle_pct = 7;
        rcv_idle_pct = 78;

        // Directed ticks under reset timings.
        //            key   refuse upd   cset  cclr  fault         mute    typed  buzz  icon
        dir_plan = '{
            '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FAULT_NONE,   1'b0}, 1'b1, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, FAULT_NONE,   1'b1}, 1'b1, '{1'b0, ICON_SHOW}},
            '{'{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, FAULT_NONE,   1'b0}, 1'b1, '{1'b0, ICON_CLEAR}},
            '{'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, FAULT_NONE,   1'b0}, 1'b1, '{1'b1, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FAULT_NONE,   1'b0}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, FAULT_NONE,   1'b0}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FAULT_NONE,   1'b0}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FAULT_NONE,   1'b0}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FAULT_NONE,   1'b0}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FAULT_ACTIVE, 1'b0}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FAULT_NONE,   1'b0}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, FAULT_NONE,   1'b0}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FAULT_SPARE,  1'b0}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, FAULT_NONE,   1'b0}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FAULT_ACTIVE, 1'b0}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FAULT_ENDED,  1'b0}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, FAULT_NONE,   1'b0}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, FAULT_NONE,   1'b0}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, FAULT_NONE,   1'b1}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, FAULT_NONE,   1'b1}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FAULT_NONE,   1'b1}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, FAULT_NONE,   1'b0}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, FAULT_SPARE,  1'b1}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FAULT_NONE,   1'b1}, 1'b0, '{1'b0, ICON_NONE}},
            '{'{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, FAULT_NONE,   1'b0}, 1'b0, '{1'b0, ICON_NONE}}
        };

        // Reset is held, then released at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++)
            offer_tick(dir_plan[i].tick, dir_plan[i].typed, dir_plan[i].want);

        // Random phases: sender rarely idles first, then the receiver, then neither.
        run_phase({8'd1, 8'd1, 8'd1, 8'd3, 8'd2, 8'd1}, 7, 78);
        run_phase({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 7, 78);
        run_phase({8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 78, 7);
        run_phase({8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                   8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                   8'($urandom_range(0, 7)), 8'($urandom_range(0, 7))}, 78, 7);
        run_phase({8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))}, 0, 0);
        run_phase({RST_SWITCH_GAP_TICKS, RST_ALARM_OFF_TICKS, RST_ALARM_ON_TICKS,
                   RST_LONG_BEEP_HALVES, RST_LONG_BEEP_TICKS, RST_KEY_BEEP_TICKS}, 0, 0);

        // Drain and settle.
        tick_ch.valid <= 1'b0;
        while (expected_outs.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (errors == 0 && expected_outs.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
